>>> sv/bmsirq_pkg.sv
package bmsirq_pkg;

	// Item codes
	localparam logic [1:0] MODE_TICK      = 2'd0;
	localparam logic [1:0] MODE_CPU_WRITE = 2'd1;
	localparam logic [1:0] MODE_CPU_READ  = 2'd2;
	localparam logic [1:0] MODE_PPU_READ  = 2'd3;

	localparam logic [1:0] SEL_NONE = 2'd0;
	localparam logic [1:0] SEL_PRG  = 2'd1;
	localparam logic [1:0] SEL_CHR  = 2'd2;

	// Configuration register indexes
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 21;
	localparam logic [CFG_INDEX_W-1:0] CFG_REG_LINE_LOW_MASK  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_REG_LINE_HIGH_MASK = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_HALF_CHR           = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_PRG_ADDRESS_MASK   = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_CHR_ADDRESS_MASK   = 3'd4;

	// Register groups by address bits 15..12
	localparam logic [3:0] TOP_PRG_FIRST  = 4'h8;
	localparam logic [3:0] TOP_MIRROR     = 4'h9;
	localparam logic [3:0] TOP_PRG_SECOND = 4'hA;
	localparam logic [3:0] TOP_CHR_FIRST  = 4'hB;
	localparam logic [3:0] TOP_CHR_LAST   = 4'hE;
	localparam logic [3:0] TOP_IRQ        = 4'hF;

	// IRQ register sub-index {sub2, sub1}
	localparam logic [1:0] IRQ_RELOAD_LOW  = 2'd0;
	localparam logic [1:0] IRQ_RELOAD_HIGH = 2'd1;
	localparam logic [1:0] IRQ_CONTROL     = 2'd2;
	localparam logic [1:0] IRQ_ACK         = 2'd3;

	localparam int CHR_BANK_COUNT = 8;
	localparam int CHR_IDX_W      = 3;
	localparam int PRESCALER_W    = 9;
	localparam logic [PRESCALER_W-1:0] PRESCALE_STEP = 9'd3;
	localparam logic [7:0] PRG_NEAR_LAST_BANK = 8'hFE;
	localparam logic [7:0] COUNTER_TOP        = 8'hFF;

	localparam logic [11:0] RESET_LOW_MASK  = 12'd2;
	localparam logic [11:0] RESET_HIGH_MASK = 12'd4;
	localparam logic [20:0] RESET_PRG_MASK  = 21'd253952;
	localparam logic [17:0] RESET_CHR_MASK  = 18'd261120;

	typedef struct packed {
		logic [1:0]  mode;
		logic [15:0] address;
		logic [7:0]  data;
	} in_item_t;

	typedef struct packed {
		logic [20:0] rom_address;
		logic [1:0]  rom_select;
		logic        irq_line;
		logic [1:0]  mirroring;
	} out_item_t;

endpackage

>>> sv/banked_mapper_with_scanline_irq.sv
// A result is registered at the edge that accepts its item.
// Throughput: one item per cycle; the next item enters while a result waits, stall permitting.
// Rate is set by the single result register; the input stalls only while that result is held.
// Reset (arst_n low, asynchronous): bank, mirroring and IRQ state clear, the prescaler
// loads PRESCALE_PERIOD, configuration returns to its default masks, no result is valid.
module banked_mapper_with_scanline_irq #(
	parameter int PRESCALE_PERIOD = 341
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  bmsirq_pkg::in_item_t                    in_item,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output bmsirq_pkg::out_item_t                   out_item,
	input  logic                                    cfg_we,
	input  logic [bmsirq_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [bmsirq_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
	import bmsirq_pkg::*;

	localparam logic [PRESCALER_W-1:0] PERIOD_RESET = PRESCALER_W'(PRESCALE_PERIOD);
	localparam logic [PRESCALER_W:0]   PERIOD_EXT   = {1'b0, PERIOD_RESET};
	localparam logic [PRESCALER_W:0]   STEP_EXT     = {1'b0, PRESCALE_STEP};

	// Configuration registers
	logic [11:0] low_mask_q;
	logic [11:0] high_mask_q;
	logic        half_chr_q;
	logic [20:0] prg_mask_q;
	logic [17:0] chr_mask_q;

	// Mapper state
	logic       prg_swap_q, prg_swap_d;
	logic [7:0] prg_first_q, prg_first_d;
	logic [7:0] prg_second_q, prg_second_d;
	logic [7:0] chr_bank_q [CHR_BANK_COUNT];
	logic [7:0] chr_bank_d [CHR_BANK_COUNT];
	logic [1:0] mirror_q, mirror_d;
	logic [7:0] reload_q, reload_d;
	logic [7:0] irq_counter_q, irq_counter_d;
	logic [PRESCALER_W-1:0] prescaler_q, prescaler_d;
	logic       irq_pending_q, irq_pending_d;
	logic       irq_enabled_q, irq_enabled_d;
	logic       enable_after_ack_q, enable_after_ack_d;
	logic       cycle_mode_q, cycle_mode_d;

	logic      in_acc;
	out_item_t result;

	// A new transaction enters unless a finished result is held back downstream.
	assign in_stall = out_valid && out_stall;
	assign in_acc   = in_valid && !in_stall;

	// Configuration is to be written only while idle (the block does not enforce it); indexes past the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_mask_q  <= RESET_LOW_MASK;
			high_mask_q <= RESET_HIGH_MASK;
			half_chr_q  <= 1'b0;
			prg_mask_q  <= RESET_PRG_MASK;
			chr_mask_q  <= RESET_CHR_MASK;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_REG_LINE_LOW_MASK:  low_mask_q  <= cfg_wdata[11:0];
				CFG_REG_LINE_HIGH_MASK: high_mask_q <= cfg_wdata[11:0];
				CFG_HALF_CHR:           half_chr_q  <= cfg_wdata[0];
				CFG_PRG_ADDRESS_MASK:   prg_mask_q  <= cfg_wdata[20:0];
				CFG_CHR_ADDRESS_MASK:   chr_mask_q  <= cfg_wdata[17:0];
				default: ;
			endcase
		end
	end

	// Next state and the result for the item at the input.
	always_comb begin
		logic [3:0]  top;
		logic        sub1;
		logic        sub2;
		logic [7:0]  wdata;
		logic [7:0]  cmask;
		logic [7:0]  pmask;
		logic        is_write;
		logic        chr_we;
		logic [CHR_IDX_W-1:0] chr_widx;
		logic [3:0]  nib;
		logic        step;
		logic [20:0] near;
		logic [20:0] base;
		logic [7:0]  rd_bank;

		prg_swap_d         = prg_swap_q;
		prg_first_d        = prg_first_q;
		prg_second_d       = prg_second_q;
		chr_bank_d         = chr_bank_q;
		mirror_d           = mirror_q;
		reload_d           = reload_q;
		irq_counter_d      = irq_counter_q;
		prescaler_d        = prescaler_q;
		irq_pending_d      = irq_pending_q;
		irq_enabled_d      = irq_enabled_q;
		enable_after_ack_d = enable_after_ack_q;
		cycle_mode_d       = cycle_mode_q;

		// Register decode: top nibble plus two sub-index bits from the line masks.
		top      = in_item.address[15:12];
		sub1     = |(in_item.address[11:0] & low_mask_q);
		sub2     = |(in_item.address[11:0] & high_mask_q);
		cmask    = chr_mask_q[17:10];
		pmask    = prg_mask_q[20:13];
		is_write = (in_item.mode == MODE_CPU_WRITE) && in_item.address[15];
		chr_we   = is_write && (top >= TOP_CHR_FIRST) && (top <= TOP_CHR_LAST);

		// Half-CHR boards wire the CHR-region data one bit over.
		wdata    = (half_chr_q && chr_we) ? {1'b0, in_item.data[7:1]} : in_item.data;
		nib      = wdata[3:0];
		chr_widx = {2'(top - TOP_CHR_FIRST), sub2};

		// CHR banks are written one nibble at a time; sub1 picks the high nibble.
		for (int i = 0; i < CHR_BANK_COUNT; i++) begin
			if (chr_we && chr_widx == CHR_IDX_W'(i)) begin
				chr_bank_d[i] = sub1 ? ({nib, chr_bank_q[i][3:0]} & cmask)
				                     : ({chr_bank_q[i][7:4], nib} & cmask);
			end
		end

		if (is_write && !chr_we) begin
			case (top)
				TOP_PRG_FIRST:  prg_first_d  = wdata & pmask;
				TOP_PRG_SECOND: prg_second_d = wdata & pmask;
				TOP_MIRROR: begin
					if (sub2) prg_swap_d = wdata[1];
					else      mirror_d   = wdata[1:0];
				end
				TOP_IRQ: begin
					case ({sub2, sub1})
						IRQ_RELOAD_LOW:  reload_d = {reload_q[7:4], wdata[3:0]};
						IRQ_RELOAD_HIGH: reload_d = {wdata[3:0], reload_q[3:0]};
						IRQ_CONTROL: begin
							enable_after_ack_d = in_item.data[0];
							irq_enabled_d      = in_item.data[1];
							cycle_mode_d       = in_item.data[2];
							irq_pending_d      = 1'b0;
							if (in_item.data[1]) begin
								irq_counter_d = reload_q;
								prescaler_d   = PERIOD_RESET;
							end
						end
						IRQ_ACK: begin
							irq_pending_d = 1'b0;
							irq_enabled_d = enable_after_ack_q;
						end
						default: ;
					endcase
				end
				default: ;
			endcase
		end

		// IRQ counter, while enabled: step every tick in cycle mode, else on each prescaler wrap.
		step = 1'b0;
		if (in_item.mode == MODE_TICK && irq_enabled_q) begin
			if (cycle_mode_q) begin
				step = 1'b1;
			end else if (prescaler_q <= PRESCALE_STEP) begin
				prescaler_d = PRESCALER_W'({1'b0, prescaler_q} + PERIOD_EXT - STEP_EXT);
				step        = 1'b1;
			end else begin
				prescaler_d = prescaler_q - PRESCALE_STEP;
			end
		end
		if (step) begin
			if (irq_counter_q == COUNTER_TOP) begin
				irq_pending_d = 1'b1;
				irq_counter_d = reload_q;
			end else begin
				irq_counter_d = irq_counter_q + 8'd1;
			end
		end

		// Address translation from the state before this item.
		near    = {PRG_NEAR_LAST_BANK, 13'd0} & prg_mask_q;
		rd_bank = chr_bank_q[in_item.address[10 +: CHR_IDX_W]];
		case (in_item.address[14:13])
			2'd0:    base = prg_swap_q ? near : {prg_first_q, 13'd0};
			2'd1:    base = {prg_second_q, 13'd0};
			2'd2:    base = prg_swap_q ? {prg_first_q, 13'd0} : near;
			default: base = prg_mask_q;
		endcase

		result.rom_address = '0;
		result.rom_select  = SEL_NONE;
		case (in_item.mode)
			MODE_CPU_READ: begin
				if (in_item.address[15]) begin
					result.rom_address = base | {8'd0, in_item.address[12:0]};
					result.rom_select  = SEL_PRG;
				end
			end
			MODE_PPU_READ: begin
				// Nametable area is unmapped; bits 15..14 are ignored.
				if (!in_item.address[13]) begin
					result.rom_address = {3'd0, rd_bank, in_item.address[9:0]};
					result.rom_select  = SEL_CHR;
				end
			end
			default: ;
		endcase
		result.irq_line  = irq_pending_d;
		result.mirroring = mirror_d;
	end

	// Advance state on each accepted transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_swap_q         <= 1'b0;
			prg_first_q        <= '0;
			prg_second_q       <= '0;
			for (int i = 0; i < CHR_BANK_COUNT; i++) chr_bank_q[i] <= '0;
			mirror_q           <= '0;
			reload_q           <= '0;
			irq_counter_q      <= '0;
			prescaler_q        <= PERIOD_RESET;
			irq_pending_q      <= 1'b0;
			irq_enabled_q      <= 1'b0;
			enable_after_ack_q <= 1'b0;
			cycle_mode_q       <= 1'b0;
			out_valid          <= 1'b0;
		end else begin
			if (in_acc) begin
				prg_swap_q         <= prg_swap_d;
				prg_first_q        <= prg_first_d;
				prg_second_q       <= prg_second_d;
				chr_bank_q         <= chr_bank_d;
				mirror_q           <= mirror_d;
				reload_q           <= reload_d;
				irq_counter_q      <= irq_counter_d;
				prescaler_q        <= prescaler_d;
				irq_pending_q      <= irq_pending_d;
				irq_enabled_q      <= irq_enabled_d;
				enable_after_ack_q <= enable_after_ack_d;
				cycle_mode_q       <= cycle_mode_d;
				out_valid          <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	// Result payload: hold while stalled, load on accept.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			out_item <= result;
		end
	end

	a_write_unmapped: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && in_item.mode == MODE_CPU_WRITE |=> out_item.rom_select == SEL_NONE)
		else $error("write transaction produced a ROM select");

	a_mirror_only_by_write: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && in_item.mode != MODE_CPU_WRITE |=> out_item.mirroring == $past(mirror_q))
		else $error("mirroring changed without a write");

	a_tick_disabled_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && in_item.mode == MODE_TICK && !irq_enabled_q
		|=> $stable(irq_counter_q) && $stable(prescaler_q) && $stable(irq_pending_q))
		else $error("IRQ state moved on a disabled tick");

	a_chr_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.rom_select == SEL_CHR |-> out_item.rom_address[20:18] == 3'd0)
		else $error("CHR address beyond 18 bits");

	a_irq_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> out_item.irq_line == irq_pending_q)
		else $error("IRQ line differs from pending flag");

endmodule
